// ----- design/ahfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hit-face classifier package
// Shared types, field widths and face codes for the swept box hit-face
// classifier pipeline.
// ----------------------------------------------------------------------------
package ahfc_pkg;

   localparam int unsigned REQ_DATA_W = 160;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned MARGIN_W   = 15;
   localparam int unsigned SPAN_W     = 18;  // coordinate differences of three terms
   localparam int unsigned HEAD_W     = 16;
   localparam int unsigned PROD_W     = SPAN_W + HEAD_W;

   typedef enum logic [1:0] {
      FACE_LEFT   = 2'd0,
      FACE_TOP    = 2'd1,
      FACE_RIGHT  = 2'd2,
      FACE_BOTTOM = 2'd3
   } face_type;

   // Request payload; the last member sits in the lowest bits.
   typedef struct packed {
      logic signed [15:0] heading_y;
      logic signed [15:0] heading_x;
      logic [14:0]        mover_height;
      logic [14:0]        mover_width;
      logic signed [15:0] mover_top;
      logic signed [15:0] mover_left;
      logic [14:0]        target_height;
      logic [14:0]        target_width;
      logic signed [15:0] target_top;
      logic signed [15:0] target_left;
   } req_type;

   // After the first stage: horizontal and vertical spans plus branch flags.
   typedef struct packed {
      logic signed [SPAN_W-1:0] span_x;
      logic signed [SPAN_W-1:0] span_y;
      logic signed [HEAD_W-1:0] heading_x;
      logic signed [HEAD_W-1:0] heading_y;
      logic                     hx_pos;
      logic                     hy_pos;
      logic                     vertical;
   } span_type;

   // After the second stage: both cross products plus branch flags.
   typedef struct packed {
      logic signed [PROD_W-1:0] cross_a;  // heading_y * span_x
      logic signed [PROD_W-1:0] cross_b;  // span_y * heading_x
      logic                     hx_pos;
      logic                     hy_pos;
      logic                     vertical;
   } cross_type;

endpackage

// ----- design/ahfc_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit-face classifier, span stage
// Picks the leading corner from the heading quadrant, forms the two spans
// between mover corner and target edges, and flags near-vertical motion.
// ----------------------------------------------------------------------------
module ahfc_prep
   import ahfc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [MARGIN_W-1:0] margin,
   input  wire logic                in_valid,
   output      logic                in_ready,
   input  wire req_type             in_data,
   output      logic                out_valid,
   input  wire logic                out_ready,
   output      span_type            out_data
);

   logic     valid_ff;
   span_type data_ff;
   span_type data_in;

   logic signed [SPAN_W-1:0] tl, tt, tw, th, ml, mt, mw, mh;
   logic signed [HEAD_W:0]   hx_ext;
   logic [HEAD_W:0]          ahx;

   always_comb begin
      tl = SPAN_W'(in_data.target_left);
      tt = SPAN_W'(in_data.target_top);
      tw = $signed({3'b000, in_data.target_width});
      th = $signed({3'b000, in_data.target_height});
      ml = SPAN_W'(in_data.mover_left);
      mt = SPAN_W'(in_data.mover_top);
      mw = $signed({3'b000, in_data.mover_width});
      mh = $signed({3'b000, in_data.mover_height});
      hx_ext = {in_data.heading_x[HEAD_W-1], in_data.heading_x};
      ahx = hx_ext[HEAD_W] ? $unsigned(-hx_ext) : $unsigned(hx_ext);

      data_in.hx_pos = !in_data.heading_x[HEAD_W-1] && (in_data.heading_x != '0);
      data_in.hy_pos = !in_data.heading_y[HEAD_W-1] && (in_data.heading_y != '0);
      data_in.vertical  = ahx <= {2'b00, margin};
      data_in.heading_x = in_data.heading_x;
      data_in.heading_y = in_data.heading_y;
      // A rightward mover leads with its right edge toward the target's left edge.
      data_in.span_x = data_in.hx_pos ? (tl - ml - mw) : (tl + tw - ml);
      // A downward mover leads with its bottom edge toward the target's top.
      data_in.span_y = data_in.hy_pos ? (tt - mt - mh) : (tt + th - mt);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/ahfc_mult.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit-face classifier, cross product stage
// Forms both sides of the slope test by cross-multiplication.
// ----------------------------------------------------------------------------
module ahfc_mult
   import ahfc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire span_type  in_data,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      cross_type out_data
);

   logic      valid_ff;
   cross_type data_ff;
   cross_type data_in;

   logic signed [SPAN_W-1:0] span_x, span_y;
   logic signed [HEAD_W-1:0] hx, hy;

   always_comb begin
      span_x = in_data.span_x;
      span_y = in_data.span_y;
      hx = in_data.heading_x;
      hy = in_data.heading_y;
      data_in.cross_a  = span_x * hy;
      data_in.cross_b  = span_y * hx;
      data_in.hx_pos   = in_data.hx_pos;
      data_in.hy_pos   = in_data.hy_pos;
      data_in.vertical = in_data.vertical;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/ahfc_decide.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit-face classifier, decision stage
// Compares the cross products per quadrant and holds the face in the
// response register.
// ----------------------------------------------------------------------------
module ahfc_decide
   import ahfc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire cross_type in_data,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      face_type  out_face
);

   logic     valid_ff;
   face_type face_ff;
   face_type face_in;

   logic b_lt_a;
   logic a_lt_b;

   always_comb begin
      b_lt_a = in_data.cross_b < in_data.cross_a;
      a_lt_b = in_data.cross_a < in_data.cross_b;
      unique case ({in_data.hx_pos, in_data.hy_pos})
         2'b11: begin
            face_in = b_lt_a ? FACE_LEFT : FACE_TOP;
         end
         2'b10: begin
            face_in = !b_lt_a ? FACE_LEFT : FACE_BOTTOM;
         end
         2'b01: begin
            // Near-vertical downward motion that is not rightward always lands on the top face.
            face_in = (!in_data.vertical && a_lt_b) ? FACE_RIGHT : FACE_TOP;
         end
         default: begin
            face_in = (!in_data.vertical && !a_lt_b) ? FACE_RIGHT : FACE_BOTTOM;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_face  = face_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         face_ff <= face_in;
      end
   end

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) reset |=> !valid_ff)
      else $error("response valid after reset");

   a_right_never_rightward: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && in_data.hx_pos) |=> (face_ff != FACE_RIGHT))
      else $error("rightward mover classified as right face");

   a_vertical_down_top: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && !in_data.hx_pos && in_data.hy_pos && in_data.vertical)
      |=> (face_ff == FACE_TOP))
      else $error("near-vertical downward mover not classified as top face");
`endif

endmodule
`default_nettype wire

// ----- design/aabb_hit_face_classifier_top.sv -----
// A request is registered in the span stage, then the cross product stage, then the
// decision stage, whose register holds the response while it is valid.
// Throughput: one request per cycle while rsp_tready is high; each stage holds one
// request and moves on when the next stage is empty or drains in the same cycle.
// The cross product stage (two 18x16 signed multipliers) sets the clock.
// Synchronous active-high reset empties the pipeline and sets the margin to 1.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swept box hit-face classifier
// Reports which face of a target box a moving box strikes: left, top, right
// or bottom, using a three-stage pipeline.
// ----------------------------------------------------------------------------
module aabb_hit_face_classifier_top
   import ahfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [MARGIN_W-1:0]   csr_wdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // Bits from 0: target_left 16, target_top 16, target_width 15,
   // target_height 15, mover_left 16, mover_top 16, mover_width 15,
   // mover_height 15, heading_x 16, heading_y 16, zero pad 4.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Bits from 0: struck_face 2, zero pad 6.
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [MARGIN_W-1:0] margin_ff;
   logic [MARGIN_W-1:0] margin_in;

   req_type   req;
   span_type  span;
   cross_type cross_data;
   logic      span_valid, span_ready;
   logic      cross_valid, cross_ready;
   face_type  face;

   assign req       = req_type'(req_tdata[$bits(req_type)-1:0]);
   assign margin_in = csr_we ? csr_wdata : margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_W'(1);
      end else begin
         margin_ff <= margin_in;
      end
   end

   ahfc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .margin    (margin_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req),
      .out_valid (span_valid),
      .out_ready (span_ready),
      .out_data  (span)
   );

   ahfc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (span_valid),
      .in_ready  (span_ready),
      .in_data   (span),
      .out_valid (cross_valid),
      .out_ready (cross_ready),
      .out_data  (cross_data)
   );

   ahfc_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cross_valid),
      .in_ready  (cross_ready),
      .in_data   (cross_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_face  (face)
   );

   assign rsp_tdata = {{(RSP_DATA_W - $bits(face_type)){1'b0}}, face};

endmodule
`default_nettype wire
